@@ src/pipt_pkg.sv @@
// ----------------------------------------------------------------------------
// pipt_pkg
// Shared constants for the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pipt_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;

    localparam int COUNT_W = 5;
    localparam int INDEX_W = 4;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 5'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

@@ src/point_in_polygon_test_top.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Even-odd ray-casting point-in-polygon test over a stored vertex list.
// ----------------------------------------------------------------------------
// Load item: written to the vertex memory at accept, no result.
// Query item with n effective vertices: one vertex memory read per cycle,
// then a 3-stage diff/multiply/compare pipe, then the result is registered;
// for n below 2 there are no reads and the result is registered directly.
// One item at a time: a load every cycle while idle; a query holds off
// new items until its result is registered; a held result stalls the next query.
// Reset: vertex_count = 2, pipeline and output empty, vertex memory undefined.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pipt_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_we,
    input  logic [pipt_pkg::COUNT_W-1:0]     cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [pipt_pkg::INDEX_W-1:0]     vertex_index,
    input  logic signed [COORD_BITS-1:0]     coord_x,
    input  logic signed [COORD_BITS-1:0]     coord_y,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             inside_res
);

    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [pipt_pkg::COUNT_W-1:0] vcount_reg;

    logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] mem_q_reg;

    logic                          in_fire;
    logic                          wr_en;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr_reg, rd_addr_next;
    logic [AW-1:0]                 last_addr_reg, last_addr_next;
    logic [CNT_W-1:0]              n_eff;

    logic signed [COORD_BITS-1:0]  px_reg, py_reg;
    logic signed [COORD_BITS-1:0]  prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0]  cur_x, cur_y;

    logic                          rv_reg, rfirst_reg;

    logic                          s1_v_reg, s1_cross_reg, s1_up_reg;
    logic signed [DW-1:0]          s1_dpx_reg, s1_dy_reg, s1_dpy_reg, s1_dx_reg;

    logic                          s2_v_reg, s2_cross_reg, s2_up_reg;
    logic signed [PW-1:0]          s2_a_reg, s2_b_reg;
    logic                          s2_hit;

    logic                          parity_reg;
    logic                          out_valid_reg, inside_reg;
    logic                          pipe_empty;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

    assign wr_en = in_fire && (cmd == pipt_pkg::CMD_LOAD)
                   && (int'(vertex_index) < MAX_VERTICES);
    assign rd_en = (state_reg == ST_RUN);

    assign n_eff = (int'(vcount_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                     : CNT_W'(vcount_reg);

    assign cur_x = mem_q_reg[COORD_BITS-1:0];
    assign cur_y = mem_q_reg[2*COORD_BITS-1:COORD_BITS];

    assign pipe_empty = !rv_reg && !s1_v_reg && !s2_v_reg;

    // vertex memory, entry = {y, x}
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(vertex_index)] <= {coord_y, coord_x};
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr_reg];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        last_addr_next = last_addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (cmd == pipt_pkg::CMD_QUERY))
                begin
                    rd_addr_next = '0;
                    if (n_eff < CNT_W'(2))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        last_addr_next = AW'(n_eff - CNT_W'(1));
                        state_next     = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (rd_addr_reg == last_addr_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= pipt_pkg::VERTEX_COUNT_RST;
            rv_reg        <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_addr_reg   <= '0;
            last_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            last_addr_reg <= last_addr_next;
            rv_reg        <= rd_en;
            s1_v_reg      <= rv_reg && !rfirst_reg;
            s2_v_reg      <= s1_v_reg;

            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end

            if (in_fire && (cmd == pipt_pkg::CMD_QUERY))
            begin
                parity_reg <= 1'b0;
            end
            else if (s2_v_reg && s2_hit)
            begin
                parity_reg <= !parity_reg;
            end

            if ((state_reg == ST_FINISH) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath: diff stage, multiply stage, compare
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_en)
        begin
            rfirst_reg <= (rd_addr_reg == '0);
        end
        if (rv_reg)
        begin
            prev_x_reg   <= cur_x;
            prev_y_reg   <= cur_y;
            s1_cross_reg <= (prev_y_reg > py_reg) != (cur_y > py_reg);
            s1_up_reg    <= cur_y > prev_y_reg;
            s1_dpx_reg   <= DW'(px_reg) - DW'(prev_x_reg);
            s1_dy_reg    <= DW'(cur_y)  - DW'(prev_y_reg);
            s1_dpy_reg   <= DW'(py_reg) - DW'(prev_y_reg);
            s1_dx_reg    <= DW'(cur_x)  - DW'(prev_x_reg);
        end
        s2_cross_reg <= s1_cross_reg;
        s2_up_reg    <= s1_up_reg;
        s2_a_reg     <= PW'(s1_dpx_reg) * PW'(s1_dy_reg);
        s2_b_reg     <= PW'(s1_dpy_reg) * PW'(s1_dx_reg);
        if ((state_reg == ST_FINISH) && (!out_valid_reg || out_ready))
        begin
            inside_reg <= parity_reg;
        end
    end

    assign s2_hit = s2_cross_reg && (s2_up_reg ? (s2_a_reg > s2_b_reg)
                                               : (s2_b_reg > s2_a_reg));

    // ------------------------------------------------------------------------
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> pipe_empty)
        else $error("edge pipeline busy while idle");

    a_finish_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> pipe_empty)
        else $error("result taken before last edge retired");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (rd_addr_reg <= last_addr_reg))
        else $error("vertex read past last vertex");

    a_drain_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |->
            ($past(state_reg) == ST_RUN || $past(state_reg) == ST_DRAIN))
        else $error("drain entered without a read sweep");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_IDLE) && pipe_empty)
        else $error("vertex write during a query");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the even-odd point-in-polygon test block.
// Random polygons are loaded vertex by vertex and probed with query points,
// many on vertices and edges. Each query answer is predicted with an exact
// cross-multiplied crossing count and checked in order as it comes out.
// ----------------------------------------------------------------------------
module tb;

    localparam int NV             = pipt_pkg::MAX_VERTICES_DEF;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic                              cmd;
        logic [pipt_pkg::INDEX_W-1:0]      idx;
        logic signed [15:0]                x;
        logic signed [15:0]                y;
    } poly_item_t;

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          cfg_we       = 1'b0;
    logic [pipt_pkg::COUNT_W-1:0]  cfg_data     = '0;
    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic                          cmd          = pipt_pkg::CMD_LOAD;
    logic [pipt_pkg::INDEX_W-1:0]  vertex_index = '0;
    logic signed [15:0]            coord_x      = '0;
    logic signed [15:0]            coord_y      = '0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic                          inside_res;

    poly_item_t            item_q [$];
    poly_item_t            tx_item;
    logic                  inside_exp_q [$];

    logic signed [15:0]    vert_x [NV];
    logic signed [15:0]    vert_y [NV];
    logic [pipt_pkg::COUNT_W-1:0] vcount = pipt_pkg::VERTEX_COUNT_RST;

    int  n_queued    = 0;
    int  n_accepted  = 0;
    int  errors      = 0;
    int  tx_gap      = 0;
    int  rx_stall    = 0;
    int  tx_gap_pct  = 0;
    int  rx_stall_pct = 0;
    int  idle_cycles = 0;
    bit  calm        = 1'b0;

    point_in_polygon_test_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .inside_res   (inside_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // even-odd crossing count, exact compare without division
    function automatic logic crossing_parity(logic signed [15:0] qx, logic signed [15:0] qy);
        int     n;
        longint px, py, x0, y0, x1, y1, lhs, rhs;
        logic   par;
        logic   hit;
        n   = (vcount > NV) ? NV : int'(vcount);
        px  = qx;
        py  = qy;
        par = 1'b0;
        for (int i = 0; i + 1 < n; i++)
        begin
            x0 = vert_x[i];
            y0 = vert_y[i];
            x1 = vert_x[i + 1];
            y1 = vert_y[i + 1];
            if ((y0 > py) != (y1 > py))
            begin
                lhs = (px - x0) * (y1 - y0);
                rhs = (py - y0) * (x1 - x0);
                hit = (y1 > y0) ? (lhs > rhs) : (rhs > lhs);
                par ^= hit;
            end
        end
        return par;
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clip16(int v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic int rand_coord(int style);
        logic [31:0] r;
        r = $urandom;
        case (style)
            0:       return rand_between(-4, 4) * 16;
            1:       return rand_between(-2000, 2000);
            2:       return int'($signed(r[15:0]));
            default:
            begin
                case (r[18:16] % 6)
                    0:       return -32768;
                    1:       return 32767;
                    2:       return 0;
                    3:       return -1;
                    4:       return 1;
                    default: return int'($signed(r[15:0]));
                endcase
            end
        endcase
    endfunction

    task automatic queue_item(logic c, int idx, int x, int y);
        poly_item_t it;
        it.cmd = c;
        it.idx = idx[pipt_pkg::INDEX_W-1:0];
        it.x   = x[15:0];
        it.y   = y[15:0];
        item_q.push_back(it);
        n_queued++;
    endtask

    task automatic set_vertex_count(logic [pipt_pkg::COUNT_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        vcount = v;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_accepted != n_queued || inside_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(int phase);
        int plan_x [NV];
        int plan_y [NV];
        int order  [NV];
        int cnt_val, n, k, style, n_q, j, tmp, qx, qy;
        int xmin, xmax, ymin, ymax;
        int pct_pick [3];
        pct_pick = '{0, 5, 20};
        case (phase)
            0:       cnt_val = 31;
            1:       cnt_val = 16;
            2:       cnt_val = 2;
            default:
            begin
                case ($urandom_range(0, 9))
                    0:       cnt_val = $urandom_range(0, 1);
                    1:       cnt_val = $urandom_range(17, 31);
                    default: cnt_val = $urandom_range(2, 16);
                endcase
            end
        endcase
        tx_gap_pct   = pct_pick[$urandom_range(0, 2)];
        rx_stall_pct = pct_pick[$urandom_range(0, 2)];
        set_vertex_count(cnt_val[pipt_pkg::COUNT_W-1:0]);

        n     = (cnt_val > NV) ? NV : cnt_val;
        k     = (n < 2) ? 2 : n;
        style = $urandom_range(0, 4);
        style = (style == 0) ? 0 : style - 1;
        for (int i = 0; i < k; i++)
        begin
            plan_x[i] = rand_coord(style);
            plan_y[i] = rand_coord(style);
            order[i]  = i;
        end
        if ($urandom_range(0, 3) != 0)
        begin
            plan_x[k - 1] = plan_x[0];
            plan_y[k - 1] = plan_y[0];
        end
        for (int i = k - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        // stray writes land first so that the real vertex wins
        for (int i = 0; i < int'($urandom_range(0, 3)); i++)
            queue_item(pipt_pkg::CMD_LOAD, $urandom_range(0, NV - 1),
                       rand_coord(2), rand_coord(2));
        for (int i = 0; i < k; i++)
            queue_item(pipt_pkg::CMD_LOAD, order[i], plan_x[order[i]], plan_y[order[i]]);

        xmin = plan_x[0]; xmax = plan_x[0]; ymin = plan_y[0]; ymax = plan_y[0];
        for (int i = 1; i < k; i++)
        begin
            if (plan_x[i] < xmin) xmin = plan_x[i];
            if (plan_x[i] > xmax) xmax = plan_x[i];
            if (plan_y[i] < ymin) ymin = plan_y[i];
            if (plan_y[i] > ymax) ymax = plan_y[i];
        end

        n_q = $urandom_range(8, 30);
        for (int q = 0; q < n_q; q++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                j = $urandom_range(0, k - 1);
                plan_x[j] = rand_coord(style);
                plan_y[j] = rand_coord(style);
                queue_item(pipt_pkg::CMD_LOAD, j, plan_x[j], plan_y[j]);
            end
            j = $urandom_range(0, k - 2);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    qx = clip16(rand_between(xmin - 16, xmax + 16));
                    qy = clip16(rand_between(ymin - 16, ymax + 16));
                end
                3, 4:
                begin
                    qx = plan_x[j];
                    qy = plan_y[j];
                end
                5, 6:
                begin
                    qx = (plan_x[j] + plan_x[j + 1]) >>> 1;
                    qy = (plan_y[j] + plan_y[j + 1]) >>> 1;
                end
                7:
                begin
                    qx = clip16(rand_between(xmin - 16, xmax + 16));
                    qy = plan_y[j];
                end
                8:
                begin
                    qx = rand_coord(2);
                    qy = rand_coord(2);
                end
                default:
                begin
                    qx = rand_coord(3);
                    qy = rand_coord(3);
                end
            endcase
            queue_item(pipt_pkg::CMD_QUERY, $urandom_range(0, NV - 1), qx, qy);
        end
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (tx_item.cmd == pipt_pkg::CMD_LOAD)
                begin
                    vert_x[tx_item.idx] = tx_item.x;
                    vert_y[tx_item.idx] = tx_item.y;
                end
                else
                    inside_exp_q.push_back(crossing_parity(tx_item.x, tx_item.y));
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (item_q.size() == 0)
                    in_valid <= 1'b0;
                else if (!calm && $urandom_range(0, 99) < tx_gap_pct)
                begin
                    tx_gap = rand_between(1, 18) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    tx_item = item_q.pop_front();
                    in_valid     <= 1'b1;
                    cmd          <= tx_item.cmd;
                    vertex_index <= tx_item.idx;
                    coord_x      <= tx_item.x;
                    coord_y      <= tx_item.y;
                end
            end
        end
    end

    task automatic report_mismatch(string what, int exp_v, int got_v);
        errors++;
        if (errors <= 10)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    endtask

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (inside_exp_q.size() == 0)
                    report_mismatch("unexpected result, inside_res", -1, inside_res);
                else if (inside_exp_q[0] !== inside_res)
                begin
                    report_mismatch("inside_res", inside_exp_q[0], inside_res);
                    void'(inside_exp_q.pop_front());
                end
                else
                    void'(inside_exp_q.pop_front());
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < rx_stall_pct)
            begin
                rx_stall = rand_between(1, 18) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL point_in_polygon_test_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int directed_n;
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // diagonal spanning the full coordinate range, reset vertex count
        queue_item(pipt_pkg::CMD_LOAD, 0, -32768, -32768);
        queue_item(pipt_pkg::CMD_LOAD, 1, 32767, 32767);
        queue_item(pipt_pkg::CMD_QUERY, 15, 32767, 0);
        queue_item(pipt_pkg::CMD_QUERY, 0, -32768, 0);
        queue_item(pipt_pkg::CMD_QUERY, 0, 0, 0);
        queue_item(pipt_pkg::CMD_QUERY, 0, -32768, -32768);
        wait_drained();

        // closed square: horizontal and vertical edges, points on the boundary
        set_vertex_count(5'd5);
        queue_item(pipt_pkg::CMD_LOAD, 0, 0, 0);
        queue_item(pipt_pkg::CMD_LOAD, 1, 16, 0);
        queue_item(pipt_pkg::CMD_LOAD, 2, 16, 16);
        queue_item(pipt_pkg::CMD_LOAD, 3, 0, 16);
        queue_item(pipt_pkg::CMD_LOAD, 4, 0, 0);
        queue_item(pipt_pkg::CMD_QUERY, 0, 8, 8);
        queue_item(pipt_pkg::CMD_QUERY, 0, 8, 0);
        queue_item(pipt_pkg::CMD_QUERY, 0, 16, 8);
        queue_item(pipt_pkg::CMD_QUERY, 0, 0, 8);
        queue_item(pipt_pkg::CMD_QUERY, 0, 16, 16);
        queue_item(pipt_pkg::CMD_QUERY, 0, -8, 8);
        wait_drained();

        // too few vertices for any edge
        set_vertex_count(5'd0);
        queue_item(pipt_pkg::CMD_QUERY, 0, 8, 8);
        wait_drained();
        set_vertex_count(5'd1);
        queue_item(pipt_pkg::CMD_QUERY, 0, 8, 8);
        wait_drained();

        directed_n = n_queued;
        phase = 0;
        while (n_queued - directed_n < RANDOM_ITEMS)
        begin
            if (n_queued - directed_n >= RANDOM_ITEMS - 250)
                calm = 1'b1;
            run_random_phase(phase);
            wait_drained();
            phase++;
        end

        if (errors == 0 && inside_exp_q.size() == 0)
            $display("PASS point_in_polygon_test_top");
        else
            $display("FAIL point_in_polygon_test_top");
        $finish;
    end

endmodule

@@ sim.f @@
src/pipt_pkg.sv
src/point_in_polygon_test_top.sv
tb/tb.sv
